// ===== sv/ddma_pkg.sv =====
`default_nettype none
package ddma_pkg;

  typedef enum logic [1:0] {
    OP_IO_RD  = 2'd0,
    OP_IO_WR  = 2'd1,
    OP_RAISE  = 2'd2,
    OP_TICK   = 2'd3
  } op_e;

  typedef enum logic [3:0] {
    A_NONE,
    A_RD_IMM,
    A_RD_ADDR,
    A_RD_CNT,
    A_RD_PAGE,
    A_WR_ADDR,
    A_WR_CNT,
    A_WR_PAGE,
    A_WR_MODE,
    A_TICK
  } act_e;

  localparam logic [3:0] REG_CMD_STAT = 4'd8;
  localparam logic [3:0] REG_REQUEST  = 4'd9;
  localparam logic [3:0] REG_SMASK    = 4'd10;
  localparam logic [3:0] REG_MODE     = 4'd11;
  localparam logic [3:0] REG_CLR_BP   = 4'd12;
  localparam logic [3:0] REG_MRESET   = 4'd13;
  localparam logic [3:0] REG_CLR_MASK = 4'd14;
  localparam logic [3:0] REG_MASK     = 4'd15;

  localparam logic [7:0] UNMAPPED  = 8'hFF;
  localparam logic [7:0] MASK_ALL  = 8'h0F;
  localparam logic [3:0] NO_PAGE   = 4'd8;

  // one entry of per-channel storage
  typedef struct packed {
    logic [15:0] page;
    logic [15:0] base_a;
    logic [15:0] cur_a;
    logic [15:0] base_c;
    logic [15:0] cur_c;
    logic [7:0]  mode;
  } chan_t;

  // item handed from decode to the read-modify-write stage
  typedef struct packed {
    act_e       act;
    logic [2:0] ch;
    logic       hi;
    logic [7:0] data;
  } s1_cmd_t;

  // terminal count event fed back to the control flops
  typedef struct packed {
    logic       hit;
    logic [2:0] ch;
  } tc_evt_t;

  function automatic logic [3:0] page_map(input logic [3:0] idx);
    logic [3:0] r;
    case (idx)
      4'd1:    r = 4'd2;
      4'd2:    r = 4'd3;
      4'd3:    r = 4'd1;
      4'd7:    r = 4'd0;
      4'd9:    r = 4'd6;
      4'd10:   r = 4'd7;
      4'd11:   r = 4'd5;
      4'd15:   r = 4'd4;
      default: r = NO_PAGE;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] set_byte(input logic [15:0] v, input logic [7:0] d,
                                           input logic hi);
    return hi ? {d, v[7:0]} : {v[15:8], d};
  endfunction

endpackage
`default_nettype wire

// ===== sv/ddma_if.sv =====
`default_nettype none
interface ddma_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  op;
  logic [10:0] port;
  logic [7:0]  wdata;
  logic [2:0]  line;
  modport source (output valid, op, port, wdata, line, input ready);
  modport sink   (input valid, op, port, wdata, line, output ready);
endinterface

interface ddma_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  read_data;
  logic        mem_valid;
  logic [31:0] mem_address;
  logic        to_memory;
  logic        wide_access;
  logic [2:0]  served_channel;
  logic        terminal_count;
  modport source (output valid, read_data, mem_valid, mem_address, to_memory, wide_access,
                  served_channel, terminal_count, input ready);
  modport sink   (input valid, read_data, mem_valid, mem_address, to_memory, wide_access,
                  served_channel, terminal_count, output ready);
endinterface
`default_nettype wire

// ===== sv/ddma_ctrl.sv =====
`default_nettype none
module ddma_ctrl (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire logic [1:0]        op_i,
  input  wire logic [10:0]       port_i,
  input  wire logic [7:0]        wdata_i,
  input  wire logic [2:0]        line_i,
  input  wire ddma_pkg::tc_evt_t tc_i,
  output ddma_pkg::s1_cmd_t      cmd_o
);
  import ddma_pkg::*;

  logic [7:0] status_q [2];
  logic [7:0] status_d [2];
  logic [7:0] mask_q   [2];
  logic [7:0] mask_d   [2];
  logic [1:0] bp_q, bp_d;
  logic [7:0] st_eff   [2];

  logic       is_c0, is_c1, is_ctl, pg_lo, pg_hi;
  logic       ctl;
  logic [3:0] rnum;
  logic [3:0] pch;
  logic [1:0] dch;
  logic [7:0] elig;
  logic       found;
  logic [2:0] pick;
  op_e        op;

  assign op    = op_e'(op_i);
  assign is_c0 = (port_i < 11'h010);
  assign is_c1 = (port_i >= 11'h0C0) && (port_i <= 11'h0DF) && !port_i[0];
  assign is_ctl = is_c0 || is_c1;
  assign ctl   = !is_c0;
  assign rnum  = is_c0 ? port_i[3:0] : port_i[4:1];
  assign pg_lo = (port_i[10:4] == 7'h08);
  assign pg_hi = (port_i[10:4] == 7'h48);
  assign pch   = page_map(port_i[3:0]);
  assign dch   = wdata_i[1:0];

  // status as seen after the previous item's terminal count lands
  always_comb begin
    st_eff[0] = status_q[0];
    st_eff[1] = status_q[1];
    if (tc_i.hit) begin
      st_eff[tc_i.ch[2]][{1'b1, tc_i.ch[1:0]}] = 1'b0;
      st_eff[tc_i.ch[2]][{1'b0, tc_i.ch[1:0]}] = 1'b1;
    end
  end

  always_comb begin
    found = 1'b0;
    pick  = '0;
    for (int i = 0; i < 8; i++) begin
      elig[i] = st_eff[i / 4][4 + (i % 4)] && !mask_q[i / 4][i % 4];
    end
    for (int i = 7; i >= 0; i--) begin
      if (elig[i]) begin
        found = 1'b1;
        pick  = 3'(i);
      end
    end
  end

  always_comb begin
    status_d = st_eff;
    mask_d   = mask_q;
    bp_d     = bp_q;
    cmd_o.act  = A_NONE;
    cmd_o.ch   = '0;
    cmd_o.hi   = 1'b0;
    cmd_o.data = wdata_i;
    if (accept_i) begin
      case (op)
        OP_IO_RD: begin
          cmd_o.act  = A_RD_IMM;
          cmd_o.data = UNMAPPED;
          if (is_ctl) begin
            if (!rnum[3]) begin
              cmd_o.act = rnum[0] ? A_RD_CNT : A_RD_ADDR;
              cmd_o.ch  = {ctl, rnum[2:1]};
              cmd_o.hi  = bp_q[ctl];
              bp_d[ctl] = !bp_q[ctl];
            end else if (rnum == REG_CMD_STAT) begin
              cmd_o.data = st_eff[ctl];
            end else if (rnum == REG_MASK) begin
              cmd_o.data = mask_q[ctl];
            end
          end else if ((pg_lo || pg_hi) && pch != NO_PAGE) begin
            cmd_o.act = A_RD_PAGE;
            cmd_o.ch  = pch[2:0];
            cmd_o.hi  = pg_hi;
          end
        end
        OP_IO_WR: begin
          if (is_ctl) begin
            if (!rnum[3]) begin
              cmd_o.act = rnum[0] ? A_WR_CNT : A_WR_ADDR;
              cmd_o.ch  = {ctl, rnum[2:1]};
              cmd_o.hi  = bp_q[ctl];
              bp_d[ctl] = !bp_q[ctl];
            end else begin
              case (rnum)
                REG_REQUEST: begin
                  status_d[ctl][{1'b0, dch}] = 1'b0;
                  status_d[ctl][{1'b1, dch}] = wdata_i[2];
                end
                REG_SMASK:    mask_d[ctl][{1'b0, dch}] = wdata_i[2];
                REG_MODE: begin
                  cmd_o.act = A_WR_MODE;
                  cmd_o.ch  = {ctl, dch};
                end
                REG_CLR_BP:   bp_d[ctl] = 1'b0;
                REG_MRESET: begin
                  bp_d[ctl]     = 1'b0;
                  status_d[ctl] = '0;
                  mask_d[ctl]   = MASK_ALL;
                end
                REG_CLR_MASK: mask_d[ctl] = '0;
                REG_MASK:     mask_d[ctl] = wdata_i;
                default: ;
              endcase
            end
          end else if ((pg_lo || pg_hi) && pch != NO_PAGE) begin
            cmd_o.act = A_WR_PAGE;
            cmd_o.ch  = pch[2:0];
            cmd_o.hi  = pg_hi;
          end
        end
        OP_RAISE: status_d[line_i[2]][{1'b1, line_i[1:0]}] = 1'b1;
        default: begin
          if (found) begin
            cmd_o.act = A_TICK;
            cmd_o.ch  = pick;
          end
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      status_q[0] <= '0;
      status_q[1] <= '0;
      mask_q[0]   <= MASK_ALL;
      mask_q[1]   <= MASK_ALL;
      bp_q        <= '0;
    end else begin
      status_q <= status_d;
      mask_q   <= mask_d;
      bp_q     <= bp_d;
    end
  end

endmodule
`default_nettype wire

// ===== sv/ddma_chan.sv =====
`default_nettype none
module ddma_chan (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              accept_i,
  input  wire ddma_pkg::s1_cmd_t cmd_i,
  output logic                   adv_o,
  output ddma_pkg::tc_evt_t      tc_o,
  ddma_out_if.source             out_o
);
  import ddma_pkg::*;

  chan_t      mem [8];
  logic [7:0] ent_vld_q;
  chan_t      rdata_q;
  logic       rvld_q;

  logic       s1_vld_q;
  s1_cmd_t    s1_q;

  logic       fwd_vld_q, fwd_vld_d;
  logic [2:0] fwd_ch_q;
  chan_t      fwd_q;

  chan_t      ent, nxt;
  logic       wr_en, tc;
  logic [7:0] rd;
  logic       mv, tm, wd;
  logic [31:0] ma;

  logic        o_vld_q;
  logic [7:0]  o_rd_q;
  logic        o_mv_q, o_tm_q, o_wd_q, o_tc_q;
  logic [31:0] o_ma_q;
  logic [2:0]  o_ch_q;

  assign adv_o = !o_vld_q || out_o.ready;

  always_comb begin
    if (fwd_vld_q && fwd_ch_q == s1_q.ch) ent = fwd_q;
    else if (rvld_q)                      ent = rdata_q;
    else                                  ent = '0;
  end

  always_comb begin
    nxt   = ent;
    wr_en = 1'b0;
    rd    = '0;
    mv    = 1'b0;
    tm    = 1'b0;
    wd    = 1'b0;
    ma    = '0;
    tc    = (ent.cur_c == 16'h0000);
    case (s1_q.act)
      A_RD_IMM:  rd = s1_q.data;
      A_RD_ADDR: rd = s1_q.hi ? ent.cur_a[15:8] : ent.cur_a[7:0];
      A_RD_CNT:  rd = s1_q.hi ? ent.cur_c[15:8] : ent.cur_c[7:0];
      A_RD_PAGE: rd = s1_q.hi ? ent.page[15:8] : ent.page[7:0];
      A_WR_ADDR: begin
        wr_en      = 1'b1;
        nxt.base_a = set_byte(ent.base_a, s1_q.data, s1_q.hi);
        nxt.cur_a  = set_byte(ent.cur_a, s1_q.data, s1_q.hi);
      end
      A_WR_CNT: begin
        wr_en      = 1'b1;
        nxt.base_c = set_byte(ent.base_c, s1_q.data, s1_q.hi);
        nxt.cur_c  = set_byte(ent.cur_c, s1_q.data, s1_q.hi);
      end
      A_WR_PAGE: begin
        wr_en    = 1'b1;
        nxt.page = set_byte(ent.page, s1_q.data, s1_q.hi);
      end
      A_WR_MODE: begin
        wr_en    = 1'b1;
        nxt.mode = s1_q.data;
      end
      A_TICK: begin
        wr_en     = 1'b1;
        mv        = 1'b1;
        wd        = s1_q.ch[2];
        tm        = (ent.mode[3:2] == 2'b01);
        ma        = {ent.page, (wd ? {ent.cur_a[14:0], 1'b0} : ent.cur_a)};
        nxt.cur_a = ent.mode[5] ? ent.cur_a - 16'd1 : ent.cur_a + 16'd1;
        nxt.cur_c = ent.cur_c - 16'd1;
        if (tc && ent.mode[4]) begin
          nxt.cur_a = ent.base_a;
          nxt.cur_c = ent.base_c;
        end
      end
      default: ;
    endcase
  end

  assign tc_o.hit = s1_vld_q && adv_o && (s1_q.act == A_TICK) && tc;
  assign tc_o.ch  = s1_q.ch;

  // channel store: read at decode, written back from the read-modify-write stage
  always_ff @(posedge clk_i) begin
    if (adv_o && s1_vld_q && wr_en) mem[s1_q.ch] <= nxt;
    if (adv_o) rdata_q <= mem[cmd_i.ch];
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      s1_q <= cmd_i;
      if (s1_vld_q && wr_en) begin
        fwd_q    <= nxt;
        fwd_ch_q <= s1_q.ch;
      end
    end
  end

  assign fwd_vld_d = adv_o ? (s1_vld_q && wr_en) : fwd_vld_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ent_vld_q <= '0;
      rvld_q    <= 1'b0;
      s1_vld_q  <= 1'b0;
      fwd_vld_q <= 1'b0;
      o_vld_q   <= 1'b0;
    end else begin
      fwd_vld_q <= fwd_vld_d;
      if (adv_o) begin
        if (s1_vld_q && wr_en) ent_vld_q[s1_q.ch] <= 1'b1;
        rvld_q   <= ent_vld_q[cmd_i.ch];
        s1_vld_q <= accept_i;
        o_vld_q  <= s1_vld_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_o) begin
      o_rd_q <= rd;
      o_mv_q <= mv;
      o_ma_q <= ma;
      o_tm_q <= tm;
      o_wd_q <= wd;
      o_ch_q <= mv ? s1_q.ch : 3'd0;
      o_tc_q <= mv && tc;
    end
  end

  assign out_o.valid          = o_vld_q;
  assign out_o.read_data      = o_rd_q;
  assign out_o.mem_valid      = o_mv_q;
  assign out_o.mem_address    = o_ma_q;
  assign out_o.to_memory      = o_tm_q;
  assign out_o.wide_access    = o_wd_q;
  assign out_o.served_channel = o_ch_q;
  assign out_o.terminal_count = o_tc_q;

  a_wide_ch: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && o_mv_q) |-> (o_wd_q == o_ch_q[2]))
    else $error("wide flag disagrees with channel");
  a_idle_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (o_vld_q && !o_mv_q) |-> (o_ch_q == 3'd0 && !o_tc_q && o_ma_q == 32'd0))
    else $error("idle result carries transfer fields");
  a_tc_tick: assert property (@(posedge clk_i) disable iff (!rst_ni)
    tc_o.hit |=> (o_vld_q && o_mv_q && o_tc_q))
    else $error("terminal count without served transaction");

endmodule
`default_nettype wire

// ===== sv/dual_dma_controller_8ch_top.sv =====
`default_nettype none
// Eight-channel DMA controller: two cascaded four-channel register sets,
// byte channels 0-3 and word channels 4-7.
// in_i  : one transaction per item: op (io read, io write, raise request
//         line, transfer tick), port, wdata, line.
// out_o : exactly one result transaction per input transaction, in order:
//         read_data for io reads, and on a tick that found an eligible
//         channel mem_valid with address, direction, width, channel and TC.
// Pipeline: decode and priority pick, with the channel-store read, in the
//   accept cycle; read-modify-write of the channel entry the next cycle;
//   result register after that, which drives out_o.valid.
// Throughput: one transaction per cycle unless stalled. A write-back to the
//   entry read by the following transaction is forwarded; a terminal count
//   from the item in flight is folded into the status seen by the next pick.
// Reset: all channel storage reads as zero, masks all set, byte pointers
//   cleared, no request pending, output empty.
// Stall: when out_o.ready is low with a result waiting, the whole pipeline
//   holds and in_i.ready drops; nothing is lost or repeated.
module dual_dma_controller_8ch_top (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ddma_in_if.sink   in_i,
  ddma_out_if.source out_o
);
  import ddma_pkg::*;

  logic    adv;
  logic    accept;
  s1_cmd_t cmd;
  tc_evt_t tc_evt;

  assign in_i.ready = adv;
  assign accept     = in_i.valid && adv;

  ddma_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .op_i     (in_i.op),
    .port_i   (in_i.port),
    .wdata_i  (in_i.wdata),
    .line_i   (in_i.line),
    .tc_i     (tc_evt),
    .cmd_o    (cmd)
  );

  ddma_chan u_chan (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .cmd_i    (cmd),
    .adv_o    (adv),
    .tc_o     (tc_evt),
    .out_o    (out_o)
  );

endmodule
`default_nettype wire

// ===== test/ddma_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none
module ddma_checker (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  ddma_in_if.sink   in_mon,
  ddma_out_if.sink  out_mon,
  output int        fail_count_o,
  output int        pending_o
);
  import ddma_pkg::*;

  typedef struct packed {
    logic [7:0]  read_data;
    logic        mem_valid;
    logic [31:0] mem_address;
    logic        to_memory;
    logic        wide_access;
    logic [2:0]  served_channel;
    logic        terminal_count;
  } dma_result_t;

  logic [15:0] m_page [8];
  logic [15:0] m_base_a [8];
  logic [15:0] m_cur_a [8];
  logic [15:0] m_base_c [8];
  logic [15:0] m_cur_c [8];
  logic [7:0]  m_mode [8];
  logic [7:0]  m_cmd [2];
  logic [7:0]  m_stat [2];
  logic [7:0]  m_mask [2];
  logic        m_bp [2];

  dma_result_t expected_q[$];
  int fails;

  assign fail_count_o = fails;
  assign pending_o    = expected_q.size();

  function automatic logic [3:0] chan_of_page(input logic [3:0] idx);
    logic [3:0] r;
    case (idx)
      4'd1: r = 4'd2;
      4'd2: r = 4'd3;
      4'd3: r = 4'd1;
      4'd7: r = 4'd0;
      4'd9: r = 4'd6;
      4'd10: r = 4'd7;
      4'd11: r = 4'd5;
      4'd15: r = 4'd4;
      default: r = NO_PAGE;
    endcase
    return r;
  endfunction

  function automatic logic [15:0] put_byte(input logic [15:0] v, input logic [7:0] d,
                                           input logic hi);
    return hi ? {d, v[7:0]} : {v[15:8], d};
  endfunction

  task automatic clear_model();
    for (int i = 0; i < 8; i++) begin
      m_page[i] = '0; m_base_a[i] = '0; m_cur_a[i] = '0;
      m_base_c[i] = '0; m_cur_c[i] = '0; m_mode[i] = '0;
    end
    for (int c = 0; c < 2; c++) begin
      m_cmd[c] = '0; m_stat[c] = '0; m_mask[c] = MASK_ALL; m_bp[c] = 1'b0;
    end
  endtask

  // decode controller register space
  function automatic bit reg_decode(input logic [10:0] p, output int ctl, output int r);
    ctl = 0; r = 0;
    if (p < 11'h10) begin
      r = p;
      return 1;
    end
    if (p >= 11'hC0 && p <= 11'hDF && !p[0]) begin
      ctl = 1; r = (p - 11'hC0) >> 1;
      return 1;
    end
    return 0;
  endfunction

  task automatic predict_dma(input op_e op, input logic [10:0] p, input logic [7:0] d,
                             input logic [2:0] ln);
    dma_result_t res;
    int ctl, r, ch;
    logic [15:0] v;
    logic [3:0] pc;
    logic tc;
    res = '0;
    case (op)
      OP_IO_RD: begin
        res.read_data = UNMAPPED;
        if (reg_decode(p, ctl, r)) begin
          if (r < 8) begin
            ch = (r >> 1) + ctl * 4;
            v = r[0] ? m_cur_c[ch] : m_cur_a[ch];
            res.read_data = m_bp[ctl] ? v[15:8] : v[7:0];
            m_bp[ctl] ^= 1'b1;
          end else if (r == REG_CMD_STAT) res.read_data = m_stat[ctl];
          else if (r == REG_MASK) res.read_data = m_mask[ctl];
        end else if ((p >= 11'h80 && p <= 11'h8F) || (p >= 11'h480 && p <= 11'h48F)) begin
          pc = chan_of_page(p[3:0]);
          if (pc != NO_PAGE) res.read_data = p[10] ? m_page[pc][15:8] : m_page[pc][7:0];
        end
      end
      OP_IO_WR: begin
        if (reg_decode(p, ctl, r)) begin
          if (r < 8) begin
            ch = (r >> 1) + ctl * 4;
            if (r[0]) begin
              m_base_c[ch] = put_byte(m_base_c[ch], d, m_bp[ctl]);
              m_cur_c[ch]  = put_byte(m_cur_c[ch], d, m_bp[ctl]);
            end else begin
              m_base_a[ch] = put_byte(m_base_a[ch], d, m_bp[ctl]);
              m_cur_a[ch]  = put_byte(m_cur_a[ch], d, m_bp[ctl]);
            end
            m_bp[ctl] ^= 1'b1;
          end else begin
            ch = d[1:0];
            case (r[3:0])
              REG_CMD_STAT: m_cmd[ctl] = d;
              REG_REQUEST: begin
                m_stat[ctl][ch] = 1'b0;
                m_stat[ctl][ch+4] = d[2];
              end
              REG_SMASK: m_mask[ctl][ch] = d[2];
              REG_MODE: m_mode[ch + ctl * 4] = d;
              REG_CLR_BP: m_bp[ctl] = 1'b0;
              REG_MRESET: begin
                m_bp[ctl] = 1'b0; m_cmd[ctl] = '0; m_stat[ctl] = '0; m_mask[ctl] = MASK_ALL;
              end
              REG_CLR_MASK: m_mask[ctl] = '0;
              default: m_mask[ctl] = d;
            endcase
          end
        end else if ((p >= 11'h80 && p <= 11'h8F) || (p >= 11'h480 && p <= 11'h48F)) begin
          pc = chan_of_page(p[3:0]);
          if (pc != NO_PAGE) m_page[pc] = put_byte(m_page[pc], d, p[10]);
        end
      end
      OP_RAISE: m_stat[ln[2]][ln[1:0] + 4] = 1'b1;
      default: begin
        ch = 8;
        for (int i = 7; i >= 0; i--)
          if (m_stat[i / 4][i % 4 + 4] && !m_mask[i / 4][i % 4]) ch = i;
        if (ch < 8) begin
          tc = (m_cur_c[ch] == 16'h0);
          res.mem_valid = 1'b1;
          res.mem_address = {m_page[ch], (ch >= 4) ? {m_cur_a[ch][14:0], 1'b0} : m_cur_a[ch]};
          res.to_memory = (m_mode[ch][3:2] == 2'b01);
          res.wide_access = (ch >= 4);
          res.served_channel = ch[2:0];
          res.terminal_count = tc;
          m_cur_a[ch] = m_mode[ch][5] ? m_cur_a[ch] - 16'd1 : m_cur_a[ch] + 16'd1;
          m_cur_c[ch] = m_cur_c[ch] - 16'd1;
          if (tc) begin
            if (m_mode[ch][4]) begin
              m_cur_a[ch] = m_base_a[ch];
              m_cur_c[ch] = m_base_c[ch];
            end
            m_stat[ch / 4][ch % 4 + 4] = 1'b0;
            m_stat[ch / 4][ch % 4] = 1'b1;
          end
        end
      end
    endcase
    expected_q.push_back(res);
  endtask

  task automatic compare_result();
    dma_result_t e;
    if (expected_q.size() == 0) begin
      $error("result with no transaction outstanding");
      fails++;
      return;
    end
    e = expected_q.pop_front();
    if (out_mon.read_data !== e.read_data) begin
      $error("read_data exp %0h got %0h", e.read_data, out_mon.read_data); fails++;
    end
    if (out_mon.mem_valid !== e.mem_valid) begin
      $error("mem_valid exp %0h got %0h", e.mem_valid, out_mon.mem_valid); fails++;
    end
    if (out_mon.mem_address !== e.mem_address) begin
      $error("mem_address exp %0h got %0h", e.mem_address, out_mon.mem_address); fails++;
    end
    if (out_mon.to_memory !== e.to_memory) begin
      $error("to_memory exp %0h got %0h", e.to_memory, out_mon.to_memory); fails++;
    end
    if (out_mon.wide_access !== e.wide_access) begin
      $error("wide_access exp %0h got %0h", e.wide_access, out_mon.wide_access); fails++;
    end
    if (out_mon.served_channel !== e.served_channel) begin
      $error("served_channel exp %0h got %0h", e.served_channel, out_mon.served_channel);
      fails++;
    end
    if (out_mon.terminal_count !== e.terminal_count) begin
      $error("terminal_count exp %0h got %0h", e.terminal_count, out_mon.terminal_count);
      fails++;
    end
  endtask

  initial begin
    fails = 0;
    clear_model();
  end

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_mon.valid && out_mon.ready) compare_result();
      if (in_mon.valid && in_mon.ready)
        predict_dma(op_e'(in_mon.op), in_mon.port, in_mon.wdata, in_mon.line);
    end
  end

endmodule
`default_nettype wire

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
`default_nettype none
module testbench;
  import ddma_pkg::*;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  int   fail_count, pending;
  bit   long_hold = 1'b0;

  ddma_in_if  in_ch ();
  ddma_out_if out_ch ();

  dual_dma_controller_8ch_top dut (
    .clk_i (clk_i),
    .rst_ni(rst_ni),
    .in_i  (in_ch.sink),
    .out_o (out_ch.source)
  );

  ddma_checker checker_u (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_mon      (in_ch.sink),
    .out_mon     (out_ch.sink),
    .fail_count_o(fail_count),
    .pending_o   (pending)
  );

  always #5 clk_i = ~clk_i;

  // Drive one transaction; holds valid until accepted. A random gap of idle
  // cycles precedes it, except during burst stretches.
  task automatic send_item(input op_e op, input logic [10:0] p, input logic [7:0] d,
                           input logic [2:0] ln, input bit no_gap);
    int gap;
    gap = no_gap ? 0 : $urandom_range(0, 13);
    repeat (gap) begin
      in_ch.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_ch.valid <= 1'b1;
    in_ch.op    <= op;
    in_ch.port  <= p;
    in_ch.wdata <= d;
    in_ch.line  <= ln;
    @(posedge clk_i);
    while (!in_ch.ready) @(posedge clk_i);
  endtask

  task automatic wr(input logic [10:0] p, input logic [7:0] d, input bit ng = 0);
    send_item(OP_IO_WR, p, d, 3'd0, ng);
  endtask

  task automatic rd(input logic [10:0] p, input bit ng = 0);
    send_item(OP_IO_RD, p, 8'h00, 3'd0, ng);
  endtask

  // Port of register r on controller c.
  function automatic logic [10:0] reg_port(input int c, input int r);
    return c ? 11'hC0 + 11'(r * 2) : 11'(r);
  endfunction

  // A random page port, low or high byte, from the mapping table's used slots.
  function automatic logic [10:0] page_port(input bit hi);
    logic [3:0] idx [8] = '{4'd1, 4'd2, 4'd3, 4'd7, 4'd9, 4'd10, 4'd11, 4'd15};
    return (hi ? 11'h480 : 11'h80) | idx[$urandom_range(0, 7)];
  endfunction

  // Program one channel for a short block transfer, then start it.
  task automatic program_channel(input int ch, input bit ng);
    int c;
    c = ch / 4;
    wr(reg_port(c, REG_CLR_BP), 8'h00, ng);
    wr(reg_port(c, (ch % 4) * 2), 8'($urandom), ng);
    wr(reg_port(c, (ch % 4) * 2), 8'($urandom), ng);
    // mostly small counts so terminal count is reached often
    wr(reg_port(c, (ch % 4) * 2 + 1), 8'($urandom_range(0, 6)), ng);
    wr(reg_port(c, (ch % 4) * 2 + 1), ($urandom_range(0, 9) == 0) ? 8'($urandom) : 8'h00, ng);
    wr(page_port($urandom_range(0, 1)), 8'($urandom), ng);
    wr(reg_port(c, REG_MODE), {8'($urandom) & 8'hFC} | 8'(ch % 4), ng);
    wr(reg_port(c, REG_SMASK), 8'(ch % 4), ng);
    if ($urandom_range(0, 1)) send_item(OP_RAISE, 11'h0, 8'h0, 3'(ch), ng);
    else wr(reg_port(c, REG_REQUEST), 8'h04 | 8'(ch % 4), ng);
  endtask

  task automatic random_noise(input bit ng);
    case ($urandom_range(0, 5))
      0: rd(11'($urandom_range(0, 1167)), ng);
      1: rd(reg_port($urandom_range(0, 1), $urandom_range(0, 15)), ng);
      2: wr(reg_port($urandom_range(0, 1), $urandom_range(8, 15)), 8'($urandom), ng);
      3: wr(11'($urandom_range(0, 1167)), 8'($urandom), ng);
      4: send_item(OP_RAISE, 11'($urandom_range(0, 2047)), 8'($urandom), 3'($urandom), ng);
      default: rd(page_port($urandom_range(0, 1)), ng);
    endcase
  endtask

  // Receiver: random stall per result, plus one long hold-off.
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    @(posedge rst_ni);
    forever begin
      if (long_hold) begin
        out_ch.ready <= 1'b0;
        repeat (60) @(posedge clk_i);
        long_hold = 1'b0;
      end
      stall = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 13);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      out_ch.ready <= 1'b1;
      @(posedge clk_i);
      while (!out_ch.valid) @(posedge clk_i);
    end
  end

  initial begin
    int sent;
    bit burst;
    in_ch.valid = 1'b0;
    in_ch.op    = OP_IO_RD;
    in_ch.port  = '0;
    in_ch.wdata = '0;
    in_ch.line  = '0;
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: reset state reads, unmapped ports, idle tick, TC at count
    // zero, auto-init reload, downward wrap, word channel addressing.
    rd(11'h008);
    rd(11'h0DE);
    rd(11'h0C1);
    rd(11'h080);
    rd(11'h7FF);
    send_item(OP_TICK, 11'h7FF, 8'hFF, 3'd7, 0);
    wr(11'h0DE, 8'h00);                 // unmask all on controller 1
    wr(11'h00B, 8'h34);                 // ch0 auto-init, down, to memory
    wr(11'h000, 8'h00);
    wr(11'h000, 8'h00);                 // address 0 -> wraps on step down
    wr(11'h001, 8'h01);
    wr(11'h001, 8'h00);
    wr(11'h00E, 8'h00);
    wr(11'h087, 8'hFF);
    wr(11'h487, 8'hFF);
    send_item(OP_RAISE, 11'h0, 8'h0, 3'd0, 0);
    send_item(OP_RAISE, 11'h0, 8'h0, 3'd7, 0);
    repeat (3) send_item(OP_TICK, 11'h0, 8'h0, 3'd0, 0);
    rd(11'h008);
    rd(11'h008);
    wr(11'h00D, 8'h00);                 // master reset
    rd(11'h00F);
    rd(11'h000);
    rd(11'h000);

    // Random: mostly programmed transfers followed by ticks, with noise.
    sent = 0;
    while (sent < 550) begin
      burst = ($urandom_range(0, 4) == 0);
      if (sent > 200 && sent < 215) long_hold = 1'b1;
      case ($urandom_range(0, 9))
        0, 1: begin
          program_channel($urandom_range(0, 7), burst);
          sent += 9;
        end
        2: begin
          random_noise(burst);
          sent++;
        end
        3: begin
          wr(reg_port($urandom_range(0, 1), REG_MASK), 8'($urandom_range(0, 15)), burst);
          sent++;
        end
        default: begin
          send_item(OP_TICK, 11'($urandom), 8'($urandom), 3'($urandom), burst);
          sent++;
        end
      endcase
    end
    in_ch.valid <= 1'b0;

    // let the checker log the last accepted transaction before draining
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (10) @(posedge clk_i);
    if (fail_count == 0) $display("** dual_dma_controller_8ch_top: PASSED **");
    else $display("** dual_dma_controller_8ch_top: FAILED **");
    $finish;
  end

  initial begin
    #2ms;
    $display("** dual_dma_controller_8ch_top: FAILED **");
    $finish;
  end

endmodule
`default_nettype wire
